### hdl/hslt_pkg.sv
package hslt_pkg;

    // fmix64 style hash step
    localparam logic [63:0] FMIX_MULT  = 64'hff51afd7ed558ccd;
    localparam int          FMIX_SHIFT = 33;
    localparam int          HALF_W     = 32;

    // Remainder reduction of the 32-bit hash word, one digit per cycle
    localparam int WORD_W    = 32;
    localparam int DIGIT_W   = 8;
    localparam int MOD_STEPS = WORD_W / DIGIT_W;
    localparam int CNT_W     = $clog2(MOD_STEPS);

    typedef enum logic [1:0] {
        CMD_LOCK       = 2'd0,
        CMD_UNLOCK     = 2'd1,
        CMD_LOCK_ALL   = 2'd2,
        CMD_UNLOCK_ALL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BUSY     = 2'd1,
        STAT_NOT_HELD = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_LL   = 2'd1,
        MUL_LH   = 2'd2,
        MUL_HL   = 2'd3
    } mul_sel_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_MUL_LL = 3'd1,
        S_MUL_LH = 3'd2,
        S_MUL_HL = 3'd3,
        S_FOLD   = 3'd4,
        S_MOD    = 3'd5,
        S_DONE   = 3'd6
    } state_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     fold;
        logic     mod_step;
        logic     commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic exclusive;
        logic out_free;
    } dp_sts_t;

endpackage

### hdl/hslt_ctrl.sv
module hslt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  hslt_pkg::dp_sts_t     dp_sts,
    output hslt_pkg::ctrl_cmd_t   ctrl_cmd,
    output logic                  req_stall
);
    import hslt_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        ctrl_cmd          = '0;
        ctrl_cmd.mul_sel  = MUL_NONE;
        req_stall         = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    ctrl_cmd.load = 1'b1;
                    state_next    = S_MUL_LL;
                end
            end
            S_MUL_LL:
            begin
                // exclusive commands need no hash
                ctrl_cmd.mul_sel = MUL_LL;
                state_next       = dp_sts.exclusive ? S_DONE : S_MUL_LH;
            end
            S_MUL_LH:
            begin
                ctrl_cmd.mul_sel = MUL_LH;
                state_next       = S_MUL_HL;
            end
            S_MUL_HL:
            begin
                ctrl_cmd.mul_sel = MUL_HL;
                state_next       = S_FOLD;
            end
            S_FOLD:
            begin
                ctrl_cmd.fold = 1'b1;
                cnt_next      = '0;
                state_next    = S_MOD;
            end
            S_MOD:
            begin
                ctrl_cmd.mod_step = 1'b1;
                if (cnt_reg == CNT_W'(MOD_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                // hold until the output register can take the result
                if (dp_sts.out_free)
                begin
                    ctrl_cmd.commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/hslt_dp.sv
module hslt_dp #(
    parameter int SHARD_COUNT = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hslt_pkg::ctrl_cmd_t   ctrl_cmd,
    output hslt_pkg::dp_sts_t     dp_sts,
    input  logic [1:0]            cmd,
    input  logic [63:0]           object_address,
    input  logic                  rsp_stall,
    output logic                  rsp_valid,
    output logic                  granted,
    output logic [4:0]            shard_index,
    output logic [1:0]            status,
    output logic [31:0]           held_vector
);
    import hslt_pkg::*;

    localparam int               REM_W   = $clog2(SHARD_COUNT);
    localparam logic [REM_W:0]   SHARD_N = (REM_W + 1)'(SHARD_COUNT);
    localparam int               TBL_N   = 1 << DIGIT_W;
    localparam int               REM_N   = 1 << REM_W;

    // digit value modulo the shard count, one entry per digit value
    function automatic logic [TBL_N*REM_W-1:0] digit_mod_table();
        logic [TBL_N*REM_W-1:0] t;
        t = '0;
        for (int v = 0; v < TBL_N; v++)
        begin
            t[v*REM_W +: REM_W] = REM_W'(v % SHARD_COUNT);
        end
        return t;
    endfunction

    // running remainder moved up one digit, modulo the shard count
    function automatic logic [REM_N*REM_W-1:0] shift_mod_table();
        logic [REM_N*REM_W-1:0] t;
        t = '0;
        for (int r = 0; r < REM_N; r++)
        begin
            t[r*REM_W +: REM_W] = REM_W'((r * TBL_N) % SHARD_COUNT);
        end
        return t;
    endfunction

    localparam logic [TBL_N*REM_W-1:0] DIGIT_MOD = digit_mod_table();
    localparam logic [REM_N*REM_W-1:0] SHIFT_MOD = shift_mod_table();

    // control state
    logic [SHARD_COUNT-1:0] held_reg;
    logic [SHARD_COUNT-1:0] held_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    // payload
    cmd_t                   cmd_reg;
    logic [63:0]            h_reg;
    logic [63:0]            acc_reg;
    logic [63:0]            acc_next;
    logic [WORD_W-1:0]      word_reg;
    logic [WORD_W-1:0]      word_next;
    logic [REM_W-1:0]       rem_reg;
    logic [REM_W-1:0]       rem_next;
    logic                   granted_reg;
    logic                   granted_next;
    logic [4:0]             index_reg;
    logic [4:0]             index_next;
    stat_t                  status_reg;
    stat_t                  status_next;

    logic [HALF_W-1:0]      mul_a;
    logic [HALF_W-1:0]      mul_b;
    logic [63:0]            mul_p;
    logic [63:0]            fold_val;
    logic [REM_W-1:0]       shift_rem;
    logic [REM_W-1:0]       digit_rem;
    logic [REM_W:0]         digit_sum;
    logic [SHARD_COUNT-1:0] shard_mask;
    logic                   shard_set;
    logic [31:0]            rem_ext;
    logic [63:0]            held_ext;

    // shared 32x32 multiplier for the three partial products
    always_comb
    begin
        mul_a = (ctrl_cmd.mul_sel == MUL_HL) ? h_reg[63:HALF_W] : h_reg[HALF_W-1:0];
        mul_b = (ctrl_cmd.mul_sel == MUL_LH) ? FMIX_MULT[63:HALF_W]
                                             : FMIX_MULT[HALF_W-1:0];
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    always_comb
    begin
        acc_next = acc_reg;
        case (ctrl_cmd.mul_sel)
            MUL_LL:   acc_next = mul_p;
            MUL_LH,
            MUL_HL:   acc_next[63:HALF_W] = acc_reg[63:HALF_W] + mul_p[HALF_W-1:0];
            default:  acc_next = acc_reg;
        endcase
    end

    // second xor-shift, then reduce modulo the shard count a digit at a time:
    // table lookups for the shifted remainder and the new digit, one
    // compare and subtract
    always_comb
    begin
        fold_val  = acc_reg ^ (acc_reg >> FMIX_SHIFT);
        shift_rem = SHIFT_MOD[int'(rem_reg) * REM_W +: REM_W];
        digit_rem = DIGIT_MOD[int'(word_reg[WORD_W-1 -: DIGIT_W]) * REM_W +: REM_W];
        digit_sum = {1'b0, shift_rem} + {1'b0, digit_rem};
        if (digit_sum >= SHARD_N)
        begin
            digit_sum = digit_sum - SHARD_N;
        end
        word_next = word_reg;
        rem_next  = rem_reg;
        if (ctrl_cmd.fold)
        begin
            word_next = fold_val[WORD_W-1:0];
            rem_next  = '0;
        end
        else if (ctrl_cmd.mod_step)
        begin
            rem_next  = digit_sum[REM_W-1:0];
            word_next = word_reg << DIGIT_W;
        end
    end

    // lock table update and result
    always_comb
    begin
        shard_mask     = {{(SHARD_COUNT - 1){1'b0}}, 1'b1} << rem_reg;
        shard_set      = held_reg[rem_reg];
        rem_ext        = 32'(rem_reg);
        held_next      = held_reg;
        granted_next   = 1'b1;
        status_next    = STAT_OK;
        index_next     = rem_ext[4:0];
        case (cmd_reg)
            CMD_LOCK:
            begin
                if (shard_set)
                begin
                    granted_next = 1'b0;
                    status_next  = STAT_BUSY;
                end
                else
                begin
                    held_next = held_reg | shard_mask;
                end
            end
            CMD_UNLOCK:
            begin
                if (!shard_set)
                begin
                    status_next = STAT_NOT_HELD;
                end
                held_next = held_reg & ~shard_mask;
            end
            CMD_LOCK_ALL:
            begin
                index_next = '0;
                if (|held_reg)
                begin
                    granted_next = 1'b0;
                    status_next  = STAT_BUSY;
                end
                else
                begin
                    held_next = '1;
                end
            end
            CMD_UNLOCK_ALL:
            begin
                index_next = '0;
                if (!(&held_reg))
                begin
                    status_next = STAT_NOT_HELD;
                end
                held_next = '0;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl_cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg & rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl_cmd.commit)
            begin
                held_reg <= held_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load)
        begin
            cmd_reg <= cmd_t'(cmd);
            h_reg   <= object_address ^ (object_address >> FMIX_SHIFT);
        end
        acc_reg  <= acc_next;
        word_reg <= word_next;
        rem_reg  <= rem_next;
        if (ctrl_cmd.commit)
        begin
            granted_reg <= granted_next;
            index_reg   <= index_next;
            status_reg  <= status_next;
        end
    end

    assign held_ext         = 64'(held_reg);
    assign dp_sts.exclusive = cmd_reg[1];
    assign dp_sts.out_free  = !out_valid_reg || !rsp_stall;
    assign rsp_valid        = out_valid_reg;
    assign granted          = granted_reg;
    assign shard_index      = index_reg;
    assign status           = status_reg;
    assign held_vector      = held_ext[31:0];

endmodule

### hdl/hashed_sharded_lock_table_core.sv
// Striped lock table of SHARD_COUNT lock bits. A request carries a command
// and an object address. Shard commands (lock, unlock) hash the address with
// an fmix64 step (xor-shift by 33, multiply by 0xff51afd7ed558ccd, xor-shift
// by 33) and take the low 32 hash bits modulo SHARD_COUNT as the shard. Lock
// grants a free shard and answers busy otherwise; the requester retries.
// Lock-all is all-or-nothing and unlock-all always clears every shard; an
// unlock of a free shard still completes but reports status "not held".
// Every request gives exactly one result item, with the lock bits as they
// stand after the request. One request is in flight at a time. A shard
// command steps through the shared 32x32 multiplier (three partial
// products, one per cycle), the second xor-shift, the modulo reduction
// (8 hash bits per cycle) and the commit, which waits for a free output
// register; the next request is accepted back in idle. Exclusive commands
// skip the remaining partial products and the reduction.
// The result sits in an output register,
// so a new request is accepted while the previous result waits on rsp_stall;
// the table commits only when that register is free. There is no clearing
// pass: the lock bits reset to all free at once.
module hashed_sharded_lock_table_core #(
    parameter int SHARD_COUNT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  cmd,
    input  logic [63:0] object_address,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        granted,
    output logic [4:0]  shard_index,
    output logic [1:0]  status,
    output logic [31:0] held_vector
);
    import hslt_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    dp_sts_t   dp_sts;

    // sequence the hash, reduction and commit
    hslt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .dp_sts    (dp_sts),
        .ctrl_cmd  (ctrl_cmd),
        .req_stall (req_stall)
    );

    // hash registers, lock bits and output register
    hslt_dp #(
        .SHARD_COUNT (SHARD_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl_cmd       (ctrl_cmd),
        .dp_sts         (dp_sts),
        .cmd            (cmd),
        .object_address (object_address),
        .rsp_stall      (rsp_stall),
        .rsp_valid      (rsp_valid),
        .granted        (granted),
        .shard_index    (shard_index),
        .status         (status),
        .held_vector    (held_vector)
    );

`ifndef ASSERT_OFF
    // commit only into a free output register
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.commit |-> dp_sts.out_free)
        else $error("commit while output register is occupied");

    // a commit always presents a result on the next cycle
    a_commit_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.commit |=> rsp_valid)
        else $error("commit did not produce a result");

    // busy is the only refusal
    a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (granted == (status != STAT_BUSY)))
        else $error("granted and status disagree");

    // datapath steps never overlap
    a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl_cmd.load, ctrl_cmd.fold, ctrl_cmd.mod_step, ctrl_cmd.commit}))
        else $error("overlapping datapath commands");
`endif

endmodule

### tb/sv/tb_hashed_sharded_lock_table_core.sv
`timescale 1ns / 1ps

import hslt_pkg::*;

// Tracks the lock bits the table should hold, predicts one result per accepted
// request and checks each result against the oldest prediction.
class lock_table_scoreboard;

    typedef struct packed {
        logic        granted;
        logic [4:0]  shard;
        stat_t       status;
        logic [31:0] held;
    } lock_result_t;

    lock_result_t expected_q[$];
    logic [31:0]  held_bits;
    int           errors;

    function new();
        held_bits = '0;
        errors    = 0;
    endfunction

    // fmix64 style step, then the low hash word modulo the shard count
    function logic [4:0] shard_of(logic [63:0] addr);
        logic [63:0] h;
        h = addr ^ (addr >> FMIX_SHIFT);
        h = h * FMIX_MULT;
        h = h ^ (h >> FMIX_SHIFT);
        return 5'(h[31:0] % 32);
    endfunction

    function void note_request(cmd_t op, logic [63:0] addr);
        lock_result_t r;
        logic [4:0]   idx;
        r.granted = 1'b0;
        r.shard   = '0;
        r.status  = STAT_OK;
        idx       = shard_of(addr);
        case (op)
            CMD_LOCK:
            begin
                r.shard = idx;
                if (held_bits[idx])
                    r.status = STAT_BUSY;
                else
                begin
                    held_bits[idx] = 1'b1;
                    r.granted      = 1'b1;
                end
            end
            CMD_UNLOCK:
            begin
                r.shard   = idx;
                r.granted = 1'b1;
                if (!held_bits[idx])
                    r.status = STAT_NOT_HELD;
                held_bits[idx] = 1'b0;
            end
            CMD_LOCK_ALL:
            begin
                if (held_bits != '0)
                    r.status = STAT_BUSY;
                else
                begin
                    held_bits = '1;
                    r.granted = 1'b1;
                end
            end
            default:
            begin
                if (held_bits != '1)
                    r.status = STAT_NOT_HELD;
                held_bits = '0;
                r.granted = 1'b1;
            end
        endcase
        r.held = held_bits;
        expected_q.push_back(r);
    endfunction

    function void check_result(logic granted, logic [4:0] shard, logic [1:0] status,
                               logic [31:0] held);
        lock_result_t e;
        if (expected_q.size() == 0)
        begin
            $display("%0t: result with nothing expected: granted %0d shard %0d status %0d held %h",
                     $time, granted, shard, status, held);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (granted !== e.granted)
        begin
            $display("%0t: granted expected %0d actual %0d", $time, e.granted, granted);
            errors++;
        end
        if (shard !== e.shard)
        begin
            $display("%0t: shard_index expected %0d actual %0d", $time, e.shard, shard);
            errors++;
        end
        if (status !== e.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
            errors++;
        end
        if (held !== e.held)
        begin
            $display("%0t: held_vector expected %h actual %h", $time, e.held, held);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

endclass

module tb_hashed_sharded_lock_table_core;

    localparam int SHARDS       = 32;
    localparam int RANDOM_ITEMS = 100;   // per idling phase
    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
    localparam int POOL_SIZE    = 24;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        req_valid      = 1'b0;
    logic [1:0]  cmd            = CMD_LOCK;
    logic [63:0] object_address = '0;
    logic        rsp_stall      = 1'b0;
    logic        req_stall;
    logic        rsp_valid;
    logic        granted;
    logic [4:0]  shard_index;
    logic [1:0]  status;
    logic [31:0] held_vector;

    // idling knobs, in percent, changed per phase
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_off      = 1'b0;

    logic [63:0] addr_pool[POOL_SIZE];

    lock_table_scoreboard sb = new();

    hashed_sharded_lock_table_core #(
        .SHARD_COUNT(SHARDS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .cmd            (cmd),
        .object_address (object_address),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .granted        (granted),
        .shard_index    (shard_index),
        .status         (status),
        .held_vector    (held_vector)
    );

    always #5 clk = ~clk;

    // Stall the result channel at random, or solidly while a hold-off runs.
    always @(posedge clk)
    begin
        rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // Check every result item taken at this edge; values are the ones
    // settled before the edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(granted, shard_index, status, held_vector);
    end

    // Hold the receiver off for a long stretch so the table backs up and
    // stalls its request side while the sender keeps offering items.
    task automatic long_hold_off();
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    endtask

    // Offer one item after a random idle gap, then wait for acceptance and
    // note it for prediction. Valid stays high into the next item.
    task automatic send_item(cmd_t op, logic [63:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid      <= 1'b1;
        cmd            <= op;
        object_address <= addr;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(op, addr);
    endtask

    // Mostly reuse a small pool of addresses so shards get locked, hit busy
    // and released again; drop in fresh addresses now and then.
    task automatic send_random_item();
        logic [63:0] addr;
        int          pick;
        cmd_t        op;
        if ($urandom_range(99) < 75)
            addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
        else
            addr = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 45)
            op = CMD_LOCK;
        else if (pick < 80)
            op = CMD_UNLOCK;
        else if (pick < 90)
            op = CMD_LOCK_ALL;
        else
            op = CMD_UNLOCK_ALL;
        send_item(op, addr);
        // now and then run a clean exclusive section
        if ($urandom_range(99) < 4)
        begin
            send_item(CMD_UNLOCK_ALL, {$urandom, $urandom});
            send_item(CMD_LOCK_ALL, {$urandom, $urandom});
            send_item(CMD_UNLOCK_ALL, {$urandom, $urandom});
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_rate, bit with_hold_off);
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        if (with_hold_off)
        begin
            fork
                long_hold_off();
            join_none
        end
        repeat (RANDOM_ITEMS) send_random_item();
    endtask

    initial
    begin
        logic [63:0] a_addr;
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = {$urandom, $urandom};
        a_addr = addr_pool[0];

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: shard grant, busy, release, release of a free shard
        send_item(CMD_LOCK, a_addr);
        send_item(CMD_LOCK, a_addr);
        send_item(CMD_UNLOCK, a_addr);
        send_item(CMD_UNLOCK, a_addr);
        // address extremes, single-bit and alternating-bit patterns
        send_item(CMD_LOCK, 64'h0);
        send_item(CMD_LOCK, '1);
        send_item(CMD_LOCK, 64'h8000_0000_0000_0000);
        send_item(CMD_LOCK, 64'h0000_0001_0000_0000);
        send_item(CMD_LOCK, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(CMD_LOCK, 64'h5555_5555_5555_5555);
        // exclusive busy while shards are held
        send_item(CMD_LOCK_ALL, '1);
        // unlock all with only some shards held
        send_item(CMD_UNLOCK_ALL, 64'h0);
        // unlock all on an empty table
        send_item(CMD_UNLOCK_ALL, '1);
        // exclusive grant and a second exclusive lock busy, then shard lock busy and shard release under it
        send_item(CMD_LOCK_ALL, 64'h1234_5678_9ABC_DEF0);
        send_item(CMD_LOCK_ALL, 64'h0);
        send_item(CMD_LOCK, a_addr);
        send_item(CMD_UNLOCK, 64'h0);
        send_item(CMD_UNLOCK_ALL, 64'h0);
        // unlock all with every shard held
        send_item(CMD_LOCK_ALL, 64'h0);
        send_item(CMD_UNLOCK_ALL, 64'h0);
        send_item(CMD_UNLOCK, '1);

        run_phase(0, 0, 1'b1);
        run_phase(50, 0, 1'b0);
        run_phase(0, 50, 1'b0);
        run_phase(33, 33, 1'b0);

        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // keep the clock running so that a stray extra result is still checked
        repeat (30) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_hashed_sharded_lock_table_core: clean");
        else
            $display("tb_hashed_sharded_lock_table_core: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("tb_hashed_sharded_lock_table_core: errors");
        $finish;
    end

endmodule
